/* rtl/tra_pkg.sv */
// ----------------------------------------------------------------------------
// tra_pkg
// Shared types, constants and helpers of the three-axis rate averager.
// ----------------------------------------------------------------------------
package tra_pkg;

  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned AXIS_W     = 2;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned SUM_W      = 21;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned MAX_BATCH  = 16;
  localparam int unsigned ADDR_W     = 3;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned DIV_CNT_W  = 5;
  localparam int unsigned REM_W      = COUNT_W + 1;

  localparam logic [ADDR_W-1:0]  REG_SAMPLES_PER_AVERAGE = 3'd0;
  localparam logic [COUNT_W-1:0] SPA_RESET               = 5'd5;
  localparam logic [AXIS_W-1:0]  LAST_AXIS               = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   dividend;
    logic [COUNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] spa);
    logic [COUNT_W-1:0] n;
    n = spa;
    if (spa == '0) begin
      n = COUNT_W'(1);
    end else if (spa > COUNT_W'(MAX_BATCH)) begin
      n = COUNT_W'(MAX_BATCH);
    end
    return n;
  endfunction

endpackage

/* rtl/tra_div.sv */
// ----------------------------------------------------------------------------
// tra_div
// Restoring divider: unsigned sum magnitude by frame count, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module tra_div
  import tra_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [REM_W-1:0]     rem;
  logic [SUM_W-1:0]     quo;
  logic [COUNT_W-1:0]   dvs;
  logic                 done;
  logic [REM_W-1:0]     shifted;
  logic                 fits;

  assign shifted = {rem[REM_W-2:0], quo[SUM_W-1]};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(SUM_W - 1);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? (shifted - {1'b0, dvs}) : shifted;
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* rtl/three_axis_rate_averager_with_zero_core.sv */
// ----------------------------------------------------------------------------
// three_axis_rate_averager_with_zero_core
// Boxcar average of three gyroscope axes with zero-offset calibration.
//
// Channel  Direction  Handshake            Payload
// in       into       in_valid/in_stall    command, {x,y,z}_{low,high}_byte
// out      out of     out_valid/out_stall  result_kind, x_rate, y_rate, z_rate
// cfg      into       APB psel/penable     samples_per_average at address 0
//
// A frame that does not close a batch is accepted in ST_IDLE and then passes
// through the shared 21-bit adder in ST_ACCUM, one axis per cycle.
// A closing frame then divides each axis sum in turn in the radix-2 divider
// and loads the output register in ST_FINISH, waiting while out_stall holds a result.
// in_stall is high from acceptance until the frame is finished.
// rst is synchronous; sums, counts and zero offsets return to zero.
// ----------------------------------------------------------------------------
module three_axis_rate_averager_with_zero_core
  import tra_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                command,
  input  logic [7:0]          x_low_byte,
  input  logic [7:0]          x_high_byte,
  input  logic [7:0]          y_low_byte,
  input  logic [7:0]          y_high_byte,
  input  logic [7:0]          z_low_byte,
  input  logic [7:0]          z_high_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                result_kind,
  output logic signed [15:0]  x_rate,
  output logic signed [15:0]  y_rate,
  output logic signed [15:0]  z_rate,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  state_t state, state_next;

  logic [COUNT_W-1:0]         samples_per_average;
  logic [COUNT_W-1:0]         count;
  logic [COUNT_W-1:0]         frames_in_batch;
  logic [COUNT_W-1:0]         frames_inc;
  logic                       batch_is_calibration;
  logic [AXIS_W-1:0]          axis;
  logic signed [SUM_W-1:0]    axis_sums    [NUM_AXES];
  logic signed [SAMPLE_W-1:0] samples      [NUM_AXES];
  logic signed [SAMPLE_W-1:0] zero_offsets [NUM_AXES];
  logic signed [SAMPLE_W-1:0] results      [NUM_AXES];

  logic                       accept;
  logic                       out_take;
  logic                       out_free;
  logic                       batch_done;
  logic signed [SUM_W-1:0]    sum_cur;
  logic signed [SUM_W-1:0]    sum_add;
  logic                       sum_neg;
  logic [SAMPLE_W-1:0]        quo16;
  logic signed [SAMPLE_W-1:0] avg;
  logic signed [SAMPLE_W-1:0] corrected;
  logic                       cfg_write;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr == REG_SAMPLES_PER_AVERAGE);
  assign prdata    = (paddr == REG_SAMPLES_PER_AVERAGE)
                     ? {{(DATA_W-COUNT_W){1'b0}}, samples_per_average} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_average <= SPA_RESET;
    end else if (cfg_write) begin
      samples_per_average <= pwdata[COUNT_W-1:0];
    end
  end

  assign count      = eff_count(samples_per_average);
  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_take   = out_valid && !out_stall;
  assign out_free   = !out_valid || !out_stall;
  assign frames_inc = frames_in_batch + COUNT_W'(1);
  assign batch_done = frames_inc >= count;

  assign sum_cur   = axis_sums[axis];
  assign sum_add   = sum_cur + SUM_W'(samples[axis]);
  assign sum_neg   = sum_cur[SUM_W-1];
  assign quo16     = div_rsp.quotient[SAMPLE_W-1:0];
  assign avg       = sum_neg ? -quo16 : quo16;
  assign corrected = avg - zero_offsets[axis];

  tra_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    div_req.start    = 1'b0;
    div_req.dividend = sum_neg ? -sum_cur : sum_cur;
    div_req.divisor  = count;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        if (axis == LAST_AXIS) begin
          state_next = batch_done ? ST_DIV_START : ST_IDLE;
        end
      end
      ST_DIV_START: begin
        div_req.start = 1'b1;
        state_next    = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_next = (axis == LAST_AXIS) ? ST_FINISH : ST_DIV_START;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis                 <= '0;
      frames_in_batch      <= '0;
      batch_is_calibration <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        axis_sums[i]    <= '0;
        zero_offsets[i] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && frames_in_batch == '0) begin
            batch_is_calibration <= command;
          end
        end
        ST_ACCUM: begin
          axis_sums[axis] <= sum_add;
          if (axis == LAST_AXIS) begin
            axis            <= '0;
            frames_in_batch <= frames_inc;
          end else begin
            axis <= axis + AXIS_W'(1);
          end
        end
        ST_DIV_START: begin
        end
        ST_DIV_WAIT: begin
          if (div_rsp.done) begin
            if (batch_is_calibration) begin
              zero_offsets[axis] <= avg;
            end
            axis <= (axis == LAST_AXIS) ? '0 : axis + AXIS_W'(1);
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            frames_in_batch      <= '0;
            batch_is_calibration <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
              axis_sums[i] <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      samples[0] <= {x_high_byte, x_low_byte};
      samples[1] <= {y_high_byte, y_low_byte};
      samples[2] <= {z_high_byte, z_low_byte};
    end
    if (state == ST_DIV_WAIT && div_rsp.done) begin
      results[axis] <= batch_is_calibration ? avg : corrected;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      result_kind <= batch_is_calibration;
      x_rate      <= results[0];
      y_rate      <= results[1];
      z_rate      <= results[2];
    end
  end

endmodule

/* rtl/tra_checker.sv */
// ----------------------------------------------------------------------------
// tra_port_props
// Port-level checks of the rate averager, bound to the top level.
// ----------------------------------------------------------------------------
module tra_port_props (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] x_rate
);

  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid set after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("new transaction taken while busy");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a transaction in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(x_rate))
    else $error("stalled result changed");

endmodule

bind three_axis_rate_averager_with_zero_core tra_port_props u_tra_port_props (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .x_rate    (x_rate)
);

/* tb/sv/tra_checker.sv */
// ----------------------------------------------------------------------------
// tra_checker
// Watches the frame, result and register channels of the rate averager,
// keeps its own running sums, batch count and zero offsets, and compares
// every accepted result field by field with the oldest predicted average.
// ----------------------------------------------------------------------------
module tra_checker
  import tra_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                command,
  input  logic [7:0]          x_low_byte,
  input  logic [7:0]          x_high_byte,
  input  logic [7:0]          y_low_byte,
  input  logic [7:0]          y_high_byte,
  input  logic [7:0]          z_low_byte,
  input  logic [7:0]          z_high_byte,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic                result_kind,
  input  logic signed [15:0]  x_rate,
  input  logic signed [15:0]  y_rate,
  input  logic signed [15:0]  z_rate,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  input  logic                pready,
  output int                  fail_count,
  output int                  pending,
  output int                  frame_count,
  output int                  result_count,
  output int                  calib_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             kind;
    logic [2:0][15:0] rate;
  } average_t;

  average_t           expected_averages[$];
  logic [COUNT_W-1:0] batch_size_reg = SPA_RESET;
  int                 axis_sum [3];
  int                 frames_taken;
  logic               batch_calib;
  logic [15:0]        zero_offset [3];

  initial begin
    fail_count   = 0;
    pending      = 0;
    frame_count  = 0;
    result_count = 0;
    calib_count  = 0;
  end

  function automatic int batch_target(input logic [COUNT_W-1:0] n);
    if (n == '0) return 1;
    if (n > MAX_BATCH) return MAX_BATCH;
    return int'(n);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic accumulate_frame();
    logic signed [15:0] sample [3];
    int                 target;
    int                 avg;
    average_t           res;
    sample[0] = {x_high_byte, x_low_byte};
    sample[1] = {y_high_byte, y_low_byte};
    sample[2] = {z_high_byte, z_low_byte};
    target = batch_target(batch_size_reg);
    if (frames_taken == 0) batch_calib = command;
    for (int i = 0; i < 3; i++) axis_sum[i] += int'(sample[i]);
    frames_taken++;
    if (frames_taken >= target) begin
      res.kind = batch_calib;
      for (int i = 0; i < 3; i++) begin
        avg = axis_sum[i] / target;
        if (batch_calib) begin
          zero_offset[i] = avg[15:0];
          res.rate[i] = avg[15:0];
        end else begin
          res.rate[i] = avg[15:0] - zero_offset[i];
        end
        axis_sum[i] = 0;
      end
      expected_averages.push_back(res);
      if (batch_calib) calib_count++;
      frames_taken = 0;
      batch_calib  = 1'b0;
    end
  endtask

  task automatic check_average();
    average_t want;
    logic [2:0][15:0] got;
    got = {z_rate, y_rate, x_rate};
    result_count++;
    if (expected_averages.size() == 0) begin
      report_mismatch($sformatf("result kind %0d x %0d y %0d z %0d with nothing expected",
                                result_kind, x_rate, y_rate, z_rate));
    end else begin
      want = expected_averages.pop_front();
      if (result_kind !== want.kind)
        report_mismatch($sformatf("result_kind got %0d expected %0d", result_kind, want.kind));
      for (int i = 0; i < 3; i++) begin
        if (got[i] !== want.rate[i])
          report_mismatch($sformatf("axis %0d rate got %0d expected %0d", i,
                                    $signed(got[i]), $signed(want.rate[i])));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_averages.delete();
      batch_size_reg = SPA_RESET;
      frames_taken   = 0;
      batch_calib    = 1'b0;
      for (int i = 0; i < 3; i++) begin
        axis_sum[i]    = 0;
        zero_offset[i] = '0;
      end
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_SAMPLES_PER_AVERAGE)
        batch_size_reg = pwdata[COUNT_W-1:0];
      if (in_valid && !in_stall) begin
        frame_count++;
        accumulate_frame();
      end
      if (out_valid && !out_stall) check_average();
    end
    pending = expected_averages.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives gyroscope frames and batch-size writes into the rate averager:
// a directed set of extreme and corner batches, then random frames over
// twelve batch sizes under four flow-control mixes. The checker beside the
// block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tra_pkg::*;

  typedef struct packed {
    logic        command;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } frame_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                command = 1'b0;
  logic [7:0]          x_low_byte = '0;
  logic [7:0]          x_high_byte = '0;
  logic [7:0]          y_low_byte = '0;
  logic [7:0]          y_high_byte = '0;
  logic [7:0]          z_low_byte = '0;
  logic [7:0]          z_high_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                result_kind;
  logic signed [15:0]  x_rate;
  logic signed [15:0]  y_rate;
  logic signed [15:0]  z_rate;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  int fail_count;
  int pending;
  int frame_count;
  int result_count;
  int calib_count;
  int idle_pct = 0;
  int stall_pct = 0;

  always #5 clk = ~clk;

  three_axis_rate_averager_with_zero_core dut (.*);

  tra_checker u_chk (.*);

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [15:0] pick_rate();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic frame_t make_frame(input logic cmd, input logic [15:0] x,
                                        input logic [15:0] y, input logic [15:0] z);
    frame_t f;
    f.command = cmd;
    f.x = x;
    f.y = y;
    f.z = z;
    return f;
  endfunction

  function automatic frame_t random_frame();
    return make_frame($urandom_range(3) == 0, pick_rate(), pick_rate(), pick_rate());
  endfunction

  task automatic send_frame(input frame_t f);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    command     <= f.command;
    x_low_byte  <= f.x[7:0];
    x_high_byte <= f.x[15:8];
    y_low_byte  <= f.y[7:0];
    y_high_byte <= f.y[15:8];
    z_low_byte  <= f.z[7:0];
    z_high_byte <= f.z[15:8];
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic drain_results();
    pause_until_drained();
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_mix(input int idle, input int stall);
    idle_pct  = idle;
    stall_pct <= stall;
  endtask

  initial begin
    int phase_counts [12];
    phase_counts = '{1, 16, 31, 2, 0, 17, 7, 4, 3, 9, 12, 5};
    phase_counts[11] = $urandom_range(31);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    repeat (5) send_frame(make_frame(1'b0, 16'h7FFF, 16'h8000, 16'h0001));
    drain_results();

    write_reg(REG_SAMPLES_PER_AVERAGE, 31);
    for (int i = 0; i < 16; i++)
      send_frame(make_frame(i == 0, 16'h8000, 16'h7FFF, i[0] ? 16'h0000 : 16'hFFFF));
    drain_results();

    write_reg(REG_SAMPLES_PER_AVERAGE, 0);
    send_frame(make_frame(1'b0, 16'h7FFF, 16'h8000, 16'h1234));
    drain_results();

    write_reg(REG_SAMPLES_PER_AVERAGE, 4);
    send_frame(make_frame(1'b0, 16'hFFFF, 16'h0001, 16'h7FFF));
    send_frame(make_frame(1'b1, 16'hFFFE, 16'h0001, 16'h7FFF));
    drain_results();
    write_reg(REG_SAMPLES_PER_AVERAGE, 2);
    send_frame(make_frame(1'b1, 16'hFFFE, 16'h0003, 16'h7FFF));
    drain_results();

    for (int p = 0; p < 12; p++) begin
      write_reg(REG_SAMPLES_PER_AVERAGE, phase_counts[p]);
      case (p % 4)
        0: set_mix(0, 0);
        1: set_mix(60, 0);
        2: set_mix(0, 60);
        default: set_mix(32, 32);
      endcase
      for (int n = 0; n < 127; n++) begin
        if (p == 5 && n % 40 == 39) pause_until_drained();
        send_frame(random_frame());
      end
      drain_results();
    end

    $display("Covered %0d frames and %0d averaged results (%0d calibrations)",
             frame_count, result_count, calib_count);
    $display("over corner batches, twelve batch sizes and four flow-control mixes.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tra_pkg.sv
rtl/tra_div.sv
rtl/three_axis_rate_averager_with_zero_core.sv
rtl/tra_checker.sv
tb/sv/tra_checker.sv
tb/sv/tb_top.sv
